// File: hdl/socks5_pkg.sv
package socks5_pkg;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] status;
        logic [7:0] reply_code;
        logic       last;
    } out_item_t;

    // operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    // status codes
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_CONN    = 3'd1;
    localparam logic [2:0] ST_METHREJ = 3'd2;
    localparam logic [2:0] ST_CONNREJ = 3'd3;
    localparam logic [2:0] ST_BADATYP = 3'd4;
    localparam logic [2:0] ST_CLOSED  = 3'd5;

    // configuration register indexes
    localparam logic REG_DEST_ADDRESS = 1'b0;
    localparam logic REG_DEST_PORT    = 1'b1;

    // protocol bytes
    localparam logic [7:0] SOCKS_VER      = 8'h05;
    localparam logic [7:0] NMETHODS_ONE   = 8'h01;
    localparam logic [7:0] METHOD_NO_AUTH = 8'h00;
    localparam logic [7:0] CMD_CONNECT    = 8'h01;
    localparam logic [7:0] RSV_ZERO       = 8'h00;
    localparam logic [7:0] REPLY_OK       = 8'h00;
    localparam logic [7:0] ATYP_IPV4      = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
    localparam logic [7:0] ATYP_IPV6      = 8'h04;
    localparam logic [8:0] SKIP_IPV4      = 9'd6;
    localparam logic [8:0] SKIP_IPV6      = 9'd18;

    // work handed from front to back
    typedef enum logic [1:0] {
        CMD_SINGLE,
        CMD_GREET,
        CMD_REQ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [2:0] status;
        logic [7:0] reply_code;
    } cmd_t;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

endpackage

// File: hdl/socks5_front.sv
module socks5_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  socks5_pkg::in_item_t in_item,
    output socks5_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_METHOD,
        PH_HEADER,
        PH_DOMLEN,
        PH_SKIP
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] byte_index_reg, byte_index_next;
    logic [8:0] skip_count_reg, skip_count_next;
    logic       header_ok_reg, header_ok_next;
    logic [7:0] saved_reply_reg, saved_reply_next;
    logic [7:0] b;

    assign b = in_item.rx_byte;

    always_comb
    begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        skip_count_next  = skip_count_reg;
        header_ok_next   = header_ok_reg;
        saved_reply_next = saved_reply_reg;
        cmd.kind         = socks5_pkg::CMD_SINGLE;
        cmd.status       = socks5_pkg::ST_BUSY;

        case (in_item.operation)
            socks5_pkg::OP_START:
            begin
                phase_next       = PH_METHOD;
                byte_index_next  = 2'd0;
                skip_count_next  = 9'd0;
                header_ok_next   = 1'b1;
                saved_reply_next = 8'd0;
                cmd.kind         = socks5_pkg::CMD_GREET;
            end
            socks5_pkg::OP_CLOSE:
            begin
                cmd.status = socks5_pkg::ST_CLOSED;
                phase_next = PH_IDLE;
            end
            socks5_pkg::OP_BYTE:
            begin
                case (phase_reg)
                    PH_METHOD:
                    begin
                        if (byte_index_reg == 2'd0)
                        begin
                            header_ok_next  = (b == socks5_pkg::SOCKS_VER);
                            byte_index_next = 2'd1;
                        end
                        else
                        begin
                            byte_index_next = 2'd0;
                            if (header_ok_reg && b == socks5_pkg::METHOD_NO_AUTH)
                            begin
                                phase_next     = PH_HEADER;
                                header_ok_next = 1'b1;
                                cmd.kind       = socks5_pkg::CMD_REQ;
                            end
                            else
                            begin
                                cmd.status = socks5_pkg::ST_METHREJ;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_HEADER:
                    begin
                        case (byte_index_reg)
                            2'd0:
                            begin
                                header_ok_next  = (b == socks5_pkg::SOCKS_VER);
                                byte_index_next = 2'd1;
                            end
                            2'd1:
                            begin
                                saved_reply_next = b;
                                byte_index_next  = 2'd2;
                            end
                            2'd2:
                            begin
                                byte_index_next = 2'd3;
                            end
                            default:
                            begin
                                // fourth header byte is the bound address type
                                byte_index_next = 2'd0;
                                if (!header_ok_reg || saved_reply_reg != socks5_pkg::REPLY_OK)
                                begin
                                    cmd.status = socks5_pkg::ST_CONNREJ;
                                    phase_next = PH_IDLE;
                                end
                                else if (b == socks5_pkg::ATYP_IPV4)
                                begin
                                    skip_count_next = socks5_pkg::SKIP_IPV4;
                                    phase_next      = PH_SKIP;
                                end
                                else if (b == socks5_pkg::ATYP_DOMAIN)
                                begin
                                    phase_next = PH_DOMLEN;
                                end
                                else if (b == socks5_pkg::ATYP_IPV6)
                                begin
                                    skip_count_next = socks5_pkg::SKIP_IPV6;
                                    phase_next      = PH_SKIP;
                                end
                                else
                                begin
                                    cmd.status = socks5_pkg::ST_BADATYP;
                                    phase_next = PH_IDLE;
                                end
                            end
                        endcase
                    end
                    PH_DOMLEN:
                    begin
                        // name length plus two port bytes
                        skip_count_next = {1'b0, b} + 9'd2;
                        phase_next      = PH_SKIP;
                    end
                    PH_SKIP:
                    begin
                        if (skip_count_reg <= 9'd1)
                        begin
                            skip_count_next = 9'd0;
                            cmd.status      = socks5_pkg::ST_CONN;
                            phase_next      = PH_IDLE;
                        end
                        else
                        begin
                            skip_count_next = skip_count_reg - 9'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        cmd.reply_code = saved_reply_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            byte_index_reg  <= 2'd0;
            skip_count_reg  <= 9'd0;
            header_ok_reg   <= 1'b1;
            saved_reply_reg <= 8'd0;
        end
        else if (in_valid)
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            skip_count_reg  <= skip_count_next;
            header_ok_reg   <= header_ok_next;
            saved_reply_reg <= saved_reply_next;
        end
    end

endmodule

// File: hdl/socks5_cmdq.sv
module socks5_cmdq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  socks5_pkg::cmd_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output socks5_pkg::cmd_t head
);

    socks5_pkg::cmd_t                  entry_reg [socks5_pkg::CMDQ_DEPTH];
    logic [socks5_pkg::CMDQ_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [socks5_pkg::CMDQ_CW-1:0]    count_reg, count_next;
    logic                              do_push, do_pop;

    assign full    = (count_reg == socks5_pkg::CMDQ_CW'(socks5_pkg::CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hdl/socks5_back.sv
module socks5_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_empty,
    input  socks5_pkg::cmd_t      cmd,
    output logic                  cmd_pop,
    input  logic [31:0]           dest_address,
    input  logic [15:0]           dest_port,
    output logic                  empty,
    input  logic                  pop,
    output socks5_pkg::out_item_t out_item
);

    logic [3:0]            idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    socks5_pkg::out_item_t out_item_reg, out_item_next;
    logic                  advance;
    logic [3:0]            last_idx;
    logic                  at_last;
    logic [7:0]            req_byte;

    assign empty    = !out_valid_reg;
    assign out_item = out_item_reg;
    assign advance  = !out_valid_reg || pop;

    always_comb
    begin
        case (cmd.kind)
            socks5_pkg::CMD_GREET: last_idx = 4'd2;
            socks5_pkg::CMD_REQ:   last_idx = 4'd9;
            default:               last_idx = 4'd0;
        endcase
    end

    // connect request: header, address and port low byte first
    always_comb
    begin
        case (idx_reg)
            4'd0:    req_byte = socks5_pkg::SOCKS_VER;
            4'd1:    req_byte = socks5_pkg::CMD_CONNECT;
            4'd2:    req_byte = socks5_pkg::RSV_ZERO;
            4'd3:    req_byte = socks5_pkg::ATYP_IPV4;
            4'd4:    req_byte = dest_address[7:0];
            4'd5:    req_byte = dest_address[15:8];
            4'd6:    req_byte = dest_address[23:16];
            4'd7:    req_byte = dest_address[31:24];
            4'd8:    req_byte = dest_port[7:0];
            default: req_byte = dest_port[15:8];
        endcase
    end

    assign at_last = (idx_reg == last_idx);
    assign cmd_pop = advance && !cmd_empty && at_last;

    always_comb
    begin
        out_item_next            = out_item_reg;
        out_valid_next           = out_valid_reg;
        idx_next                 = idx_reg;
        if (advance)
        begin
            out_valid_next = !cmd_empty;
            if (!cmd_empty)
            begin
                out_item_next.reply_code = cmd.reply_code;
                out_item_next.last       = at_last;
                out_item_next.status     = at_last ? cmd.status : socks5_pkg::ST_BUSY;
                idx_next                 = at_last ? 4'd0 : idx_reg + 4'd1;
                case (cmd.kind)
                    socks5_pkg::CMD_GREET:
                    begin
                        out_item_next.tx_valid = 1'b1;
                        case (idx_reg)
                            4'd0:    out_item_next.tx_byte = socks5_pkg::SOCKS_VER;
                            4'd1:    out_item_next.tx_byte = socks5_pkg::NMETHODS_ONE;
                            default: out_item_next.tx_byte = socks5_pkg::METHOD_NO_AUTH;
                        endcase
                    end
                    socks5_pkg::CMD_REQ:
                    begin
                        out_item_next.tx_valid = 1'b1;
                        out_item_next.tx_byte  = req_byte;
                    end
                    default:
                    begin
                        out_item_next.tx_valid = 1'b0;
                        out_item_next.tx_byte  = 8'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

// File: hdl/socks5_client_connect_handshake.sv
// socks5 client connect handshake, no authentication, ipv4 destination
//
// input queue side: push an item (operation, rx_byte) when full is low.
// result queue side: the oldest result sits on out_item while empty is low,
// pop takes it. config: cfg_write with cfg_index 0 (dest_address) or
// 1 (dest_port) and cfg_data; write only while the block is idle.
//
// a front stage runs the protocol state machine, one item per cycle while full is low, and
// places a command in a 4-entry queue. a back stage expands each command into
// result items, one per cycle while results are popped, into an output register.
// the first result of an item passes through the queue and the output register to the result ports.
// throughput: 1 item per cycle for items giving one result while results are popped; start
// gives 3 result items and the method reply that triggers the request gives 10,
// during which the queue absorbs following items until it fills.
// when pop is held low the output register holds, the back stage stops, and
// full rises once the command queue is full.
// reset clears the state machine, the queue and the output valid flag, not the output data;
// dest_address and dest_port reset to zero.
module socks5_client_connect_handshake (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  socks5_pkg::in_item_t  in_item,
    output logic                  empty,
    input  logic                  pop,
    output socks5_pkg::out_item_t out_item,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data
);

    logic [31:0]      dest_address_reg;
    logic [15:0]      dest_port_reg;
    logic             accept;
    socks5_pkg::cmd_t front_cmd;
    socks5_pkg::cmd_t head_cmd;
    logic             cmdq_empty;
    logic             cmdq_pop;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_address_reg <= 32'd0;
            dest_port_reg    <= 16'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                socks5_pkg::REG_DEST_ADDRESS: dest_address_reg <= cfg_data;
                socks5_pkg::REG_DEST_PORT:    dest_port_reg    <= cfg_data[15:0];
                default:                      dest_port_reg    <= dest_port_reg;
            endcase
        end
    end

    socks5_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_item  (in_item),
        .cmd      (front_cmd)
    );

    socks5_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .full      (full),
        .pop       (cmdq_pop),
        .empty     (cmdq_empty),
        .head      (head_cmd)
    );

    socks5_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cmdq_empty),
        .cmd          (head_cmd),
        .cmd_pop      (cmdq_pop),
        .dest_address (dest_address_reg),
        .dest_port    (dest_port_reg),
        .empty        (empty),
        .pop          (pop),
        .out_item     (out_item)
    );

endmodule

// File: hdl/socks5_checker.sv
module socks5_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  empty,
    input logic                  pop,
    input socks5_pkg::out_item_t out_item
);

    // nothing waits on the result side while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result waiting during reset");

    // a final status only ever rides on the last result of an item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.status != socks5_pkg::ST_BUSY) |-> out_item.last)
        else $error("status on a result that is not last");

    // results with no byte to send carry a zero byte
    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.tx_valid) |-> (out_item.tx_byte == 8'd0))
        else $error("tx_byte set without tx_valid");

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed while stalled");

endmodule

bind socks5_client_connect_handshake socks5_checker u_socks5_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
